FILE: design/emc_pkg.sv
package emc_pkg;

  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_BRIDGE  = 2'd1,
    OP_LINK    = 2'd2,
    OP_TICK    = 2'd3
  } emc_op_e;

  localparam logic [7:0] THRESH_RESET = 8'd25;
  localparam logic [7:0] ATT_RESET    = 8'd50;
  localparam logic [7:0] FAT_RESET    = 8'd0;
  localparam logic [7:0] REL_RESET    = 8'd50;
  localparam logic [7:0] QUAL_RESET   = 8'd0;

  localparam logic [7:0] QUAL_LEN1    = 8'd50;
  localparam logic [7:0] QUAL_LEN2    = 8'd80;
  localparam logic [7:0] METRIC_FULL  = 8'd100;
  localparam logic [7:0] FAT_KNEE     = 8'd60;
  localparam logic [7:0] FAT_OFFSET   = 8'd40;

  localparam logic [2:0] LEN_NONE     = 3'd0;
  localparam logic [2:0] LEN_TWO      = 3'd2;
  localparam logic [2:0] LEN_THREE    = 3'd3;
  localparam logic [2:0] LEN_FULL     = 3'd4;

  typedef struct packed {
    emc_op_e    op;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [2:0] frame_length;
    logic       link_flag;
  } emc_item_t;

  typedef struct packed {
    logic [7:0] attention;
    logic [7:0] fatigue;
    logic [7:0] relax;
    logic [7:0] quality;
  } emc_metrics_t;

endpackage

FILE: design/emc_if.sv
interface emc_item_if import emc_pkg::*; ();
  logic       valid;
  logic       ready;
  emc_op_e    op;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;
  logic [7:0] byte_d;
  logic [2:0] frame_length;
  logic       link_flag;

  modport source (
    output valid, op, byte_a, byte_b, byte_c, byte_d, frame_length, link_flag,
    input  ready
  );
  modport sink (
    input  valid, op, byte_a, byte_b, byte_c, byte_d, frame_length, link_flag,
    output ready
  );
endinterface

interface emc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] attention;
  logic [7:0] fatigue;
  logic [7:0] relax;
  logic [7:0] quality;
  logic       linked;

  modport source (
    output valid, attention, fatigue, relax, quality, linked,
    input  ready
  );
  modport sink (
    input  valid, attention, fatigue, relax, quality, linked,
    output ready
  );
endinterface

interface emc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

FILE: design/eeg_metric_conditioner.sv
// Headset metric conditioner. Each transaction on item_i is taken into an input
// register and then resolved against the held sample; an item that gives a
// result writes it into the result register on result_o, so a sample is
// presented from that register once its item leaves the input register.
// One item is accepted in every cycle while results are taken. An item that
// gives a result stays in the input register while an earlier result waits on
// result_o, and the input is not ready in that case. An item that gives no
// result is never held up by a waiting result.
// Link-state items and payload frames of zero length update state (or nothing)
// and give no result. The per-cycle limit is the feedback loop from the held
// sample registers through the derive, hold and blend logic back into them.
// The quality threshold is written through cfg_i, which is always ready.
module eeg_metric_conditioner import emc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  emc_cfg_if.sink     cfg_i,
  emc_item_if.sink    item_i,
  emc_result_if.source result_o
);

  function automatic logic [7:0] hundred_minus(input logic [7:0] v);
    return (v <= METRIC_FULL) ? METRIC_FULL - v : 8'd0;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] old_v, input logic [7:0] new_v);
    logic [9:0] sum;
    sum = ({2'b00, old_v} << 1) + {2'b00, old_v} + {2'b00, new_v} + 10'd2;
    return sum[9:2];
  endfunction

  logic [7:0]   thresh_q;
  emc_item_t    stage_q, stage_d;
  logic         stage_valid_q, stage_valid_d;
  emc_metrics_t held_q, held_d;
  logic         link_q, link_d;
  logic         armed_q, armed_d;
  emc_metrics_t res_q, res_d;
  logic         res_linked_q, res_linked_d;
  logic         res_valid_q, res_valid_d;

  emc_metrics_t fresh, sample;
  logic         finish_op, produce, advance, fire;
  logic [7:0]   tick_quality;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !stage_valid_q || advance;

  assign result_o.valid     = res_valid_q;
  assign result_o.attention = res_q.attention;
  assign result_o.fatigue   = res_q.fatigue;
  assign result_o.relax     = res_q.relax;
  assign result_o.quality   = res_q.quality;
  assign result_o.linked    = res_linked_q;

  // Derive and blend the new payload or bridge sample; pick the tick quality.
  always_comb begin
    fresh     = '0;
    finish_op = 1'b0;
    produce   = 1'b0;
    case (stage_q.op)
      OP_PAYLOAD: begin
        if (stage_q.frame_length != LEN_NONE) begin
          finish_op       = 1'b1;
          produce         = 1'b1;
          fresh.attention = stage_q.byte_a;
          if (stage_q.frame_length >= LEN_FULL) begin
            fresh.fatigue = stage_q.byte_b;
            fresh.relax   = stage_q.byte_c;
            fresh.quality = stage_q.byte_d;
          end else if (stage_q.frame_length == LEN_THREE) begin
            fresh.fatigue = stage_q.byte_b;
            fresh.relax   = hundred_minus(stage_q.byte_b);
            fresh.quality = stage_q.byte_c;
          end else if (stage_q.frame_length == LEN_TWO) begin
            fresh.fatigue = stage_q.byte_b;
            fresh.relax   = hundred_minus(stage_q.byte_b);
            fresh.quality = QUAL_LEN2;
          end else begin
            fresh.fatigue = (stage_q.byte_a > FAT_KNEE) ? stage_q.byte_a - FAT_OFFSET : 8'd0;
            fresh.relax   = hundred_minus(stage_q.byte_a);
            fresh.quality = QUAL_LEN1;
          end
          // A poor-quality frame keeps the previous attention, fatigue and relax.
          if (fresh.quality < thresh_q) begin
            fresh.attention = held_q.attention;
            fresh.fatigue   = held_q.fatigue;
            fresh.relax     = held_q.relax;
          end
        end
      end
      OP_BRIDGE: begin
        finish_op       = 1'b1;
        produce         = 1'b1;
        fresh.attention = stage_q.byte_a;
        fresh.fatigue   = hundred_minus(stage_q.byte_b);
        fresh.relax     = stage_q.byte_b;
        fresh.quality   = stage_q.byte_c;
      end
      OP_TICK: begin
        produce = 1'b1;
      end
      default: begin
        produce = 1'b0;
      end
    endcase

    if (armed_q && link_q) begin
      sample.attention = blend(held_q.attention, fresh.attention);
      sample.fatigue   = blend(held_q.fatigue, fresh.fatigue);
      sample.relax     = blend(held_q.relax, fresh.relax);
      sample.quality   = blend(held_q.quality, fresh.quality);
    end else begin
      sample = fresh;
    end
    tick_quality = link_q ? held_q.quality : 8'd0;
  end

  assign advance = !produce || !res_valid_q || result_o.ready;
  assign fire    = stage_valid_q && advance;

  always_comb begin
    held_d       = held_q;
    link_d       = link_q;
    armed_d      = armed_q;
    res_d        = res_q;
    res_linked_d = res_linked_q;
    res_valid_d  = res_valid_q && !result_o.ready;
    if (fire) begin
      if (finish_op) begin
        held_d       = sample;
        link_d       = 1'b1;
        armed_d      = 1'b1;
        res_d        = sample;
        res_linked_d = 1'b1;
        res_valid_d  = 1'b1;
      end else if (stage_q.op == OP_LINK) begin
        link_d = stage_q.link_flag;
        if (!stage_q.link_flag) begin
          held_d.quality = 8'd0;
          armed_d        = 1'b0;
        end
      end else if (stage_q.op == OP_TICK) begin
        held_d.quality = tick_quality;
        res_d          = held_q;
        res_d.quality  = tick_quality;
        res_linked_d   = link_q;
        res_valid_d    = 1'b1;
      end
    end

    stage_d       = stage_q;
    stage_valid_d = stage_valid_q && !advance;
    if (item_i.valid && item_i.ready) begin
      stage_d.op           = item_i.op;
      stage_d.byte_a       = item_i.byte_a;
      stage_d.byte_b       = item_i.byte_b;
      stage_d.byte_c       = item_i.byte_c;
      stage_d.byte_d       = item_i.byte_d;
      stage_d.frame_length = item_i.frame_length;
      stage_d.link_flag    = item_i.link_flag;
      stage_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q          <= THRESH_RESET;
      stage_valid_q     <= 1'b0;
      held_q.attention  <= ATT_RESET;
      held_q.fatigue    <= FAT_RESET;
      held_q.relax      <= REL_RESET;
      held_q.quality    <= QUAL_RESET;
      link_q            <= 1'b0;
      armed_q           <= 1'b0;
      res_valid_q       <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        thresh_q <= cfg_i.data;
      end
      stage_valid_q <= stage_valid_d;
      held_q        <= held_d;
      link_q        <= link_d;
      armed_q       <= armed_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q      <= stage_d;
    res_q        <= res_d;
    res_linked_q <= res_linked_d;
  end

  // Smoothing is only ever armed while the link is up.
  a_armed_needs_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> link_q)
    else $error("smoothing armed while link is down");

  // A sample that reports the link down carries zero quality.
  a_down_quality_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.linked) |-> (result_o.quality == 8'd0))
    else $error("nonzero quality on an unlinked sample");

  // A stalled item must leave the held sample untouched.
  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && !advance) |=> ($stable(held_q) && $stable(link_q)))
    else $error("held sample changed while the item was stalled");

endmodule
